@@ sv/dst_pkg.sv @@
// Shared types and constants of the descriptor slot table.
// Used by the channel interfaces and the top level.
// Depends on nothing.
package dst_pkg;

	// Fixed field widths of the request and response channels.
	localparam int MODE_W     = 3;
	localparam int HANDLE_W   = 16;
	localparam int SLOT_W     = 8;
	localparam int SLOT_OUT_W = 6;
	localparam int STATUS_W   = 2;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_LOOKUP = 3'd2,
		MODE_EXEC   = 3'd3,
		MODE_DUP    = 3'd4,
		MODE_DUP2   = 3'd5
	} mode_t;

	// Completion status of an operation.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_BADF  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

endpackage

@@ sv/dst_in_if.sv @@
// Request channel of the descriptor slot table: valid, ready and the operation fields.
// Depends on dst_pkg for the field widths.
interface dst_in_if import dst_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [HANDLE_W-1:0] file_handle;
	logic [SLOT_W-1:0]   slot_index;
	logic [SLOT_W-1:0]   new_slot;
	logic                close_on_exec;
	logic                bad_flags;

	modport source (
		output valid, mode, file_handle, slot_index, new_slot, close_on_exec, bad_flags,
		input  ready
	);

	modport sink (
		input  valid, mode, file_handle, slot_index, new_slot, close_on_exec, bad_flags,
		output ready
	);
endinterface

@@ sv/dst_out_if.sv @@
// Response channel of the descriptor slot table: valid, ready and the result fields.
// Depends on dst_pkg for the field widths.
interface dst_out_if import dst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [HANDLE_W-1:0]   file_out;
	logic                  close_valid;
	logic [HANDLE_W-1:0]   close_handle;
	logic                  last;

	modport source (
		output valid, status, slot_out, file_out, close_valid, close_handle, last,
		input  ready
	);

	modport sink (
		input  valid, status, slot_out, file_out, close_valid, close_handle, last,
		output ready
	);
endinterface

@@ sv/dst_ffs.sv @@
// Registered find-first-set over a bit vector, split into groups of up to sixteen bits.
// The result reflects the vector of the previous cycle. Depends on nothing.
module dst_ffs #(
	parameter int WIDTH = 64,
	localparam int IDXW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] vec,
	output logic             found,
	output logic [IDXW-1:0]  index
);
	localparam int GRP  = (WIDTH < 16) ? WIDTH : 16;
	localparam int NG   = WIDTH / GRP;
	localparam int OFFW = (GRP > 1) ? $clog2(GRP) : 1;

	logic [NG-1:0]   any_d;
	logic [OFFW-1:0] off_d   [NG];
	logic [NG-1:0]   any_s1;
	logic [OFFW-1:0] off_s1  [NG];

	// First level: lowest set bit inside each group.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			any_d[g] = 1'b0;
			off_d[g] = '0;
			for (int b = GRP - 1; b >= 0; b--) begin
				if (vec[g * GRP + b]) begin
					any_d[g] = 1'b1;
					off_d[g] = OFFW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1 <= '0;
		end else begin
			any_s1 <= any_d;
		end
	end

	always_ff @(posedge clk) begin
		off_s1 <= off_d;
	end

	// Second level: lowest group that has a set bit.
	always_comb begin
		found = 1'b0;
		index = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				found = 1'b1;
				index = IDXW'(g * GRP + int'(off_s1[g]));
			end
		end
	end
endmodule

@@ sv/descriptor_slot_table.sv @@
// Descriptor slot table top level: handle memory, slot bitmaps and the operation sequencer.
// Depends on dst_pkg, dst_in_if, dst_out_if and dst_ffs.
//
//   channel  direction  transfer carries
//   req      in         mode, file_handle, slot_index, new_slot, close_on_exec, bad_flags
//   rsp      out        status, slot_out, file_out, close_valid, close_handle, last
//
// One operation is in flight at a time. Create, lookup and dup answer from the lookup state, dup2
// adds a write state, remove reads the slots in use one at a time until one matches or none is
// left, and exec close frees the flagged slots one at a time.
// These steps follow from the single read port of the handle memory and the registered
// find-first unit over the slot bitmaps. Reset clears the in-use and close-on-exec
// bitmaps at once, so no clearing pass is needed. A stalled response holds the sequencer
// in place; the next request is taken while the final response still waits.
module descriptor_slot_table import dst_pkg::*; #(
	parameter int SLOTS       = 64,
	parameter int HANDLE_BITS = 16
) (
	input logic     clk,
	input logic     arst_n,
	dst_in_if.sink  req,
	dst_out_if.source rsp
);
	localparam int IW    = $clog2(SLOTS);
	localparam int DEPTH = 1 << IW;
	localparam int HW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_RM_ISSUE,
		S_RM_CMP,
		S_XC_ISSUE,
		S_XC_DATA,
		S_D2_WR
	} state_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_OUT_W-1:0] slot_out;
		logic [HANDLE_W-1:0]   file_out;
		logic                  close_valid;
		logic [HANDLE_W-1:0]   close_handle;
		logic                  last;
	} rsp_t;

	state_t state_q, state_d;

	// Latched request fields.
	logic [MODE_W-1:0] mode_q;
	logic [HW-1:0]     h_q;
	logic [IW-1:0]     src_idx_q;
	logic [IW-1:0]     dst_idx_q;
	logic              src_rng_q;
	logic              dst_rng_q;
	logic              cl_q;
	logic              bad_q;

	// Slot bitmaps and scan bookkeeping.
	logic [DEPTH-1:0] used_q;
	logic [DEPTH-1:0] cloexec_q;
	logic [DEPTH-1:0] vis_q;
	logic [DEPTH-1:0] valid_mask;
	logic [IW-1:0]    cand_q;
	logic             pend_q;
	logic [HW-1:0]    pend_h_q;
	logic [HW-1:0]    tmp_q;

	// Handle memory.
	logic [HW-1:0] mem [DEPTH];
	logic [HW-1:0] rd_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [HW-1:0] wr_data;

	// Sequencer controls.
	logic          accept;
	logic          can_emit;
	logic          emit;
	rsp_t          rsp_d;
	rsp_t          out_q;
	logic          out_valid_q;
	logic          bm_we;
	logic [IW-1:0] bm_idx;
	logic          bm_used;
	logic          bm_cx;
	logic          vis_set;
	logic          cand_load;
	logic          pend_load;
	logic          tmp_load;
	logic          src_ok;

	// Find-first unit.
	logic [MODE_W-1:0] ff_mode;
	logic [DEPTH-1:0]  ff_vec;
	logic              ff_found;
	logic [IW-1:0]     ff_idx;

	assign accept   = req.valid && req.ready;
	assign can_emit = !out_valid_q || rsp.ready;
	assign src_ok   = src_rng_q && used_q[src_idx_q];

	// Slots past the configured count never take part in a search.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid_mask[i] = (i < SLOTS);
		end
	end

	// The search vector follows the incoming mode while idle, so the result is ready
	// in the cycle after the transfer.
	always_comb begin
		ff_mode = (state_q == S_IDLE) ? req.mode : mode_q;
		case (ff_mode)
			MODE_CREATE, MODE_DUP: ff_vec = ~used_q & valid_mask;
			MODE_REMOVE:           ff_vec = (state_q == S_IDLE) ? used_q : (used_q & ~vis_q);
			MODE_EXEC:             ff_vec = used_q & cloexec_q;
			default:               ff_vec = '0;
		endcase
	end

	dst_ffs #(.WIDTH(DEPTH)) u_ffs (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (ff_vec),
		.found  (ff_found),
		.index  (ff_idx)
	);

	// Operation sequencer: decides the next state, memory accesses and the response.
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		rsp_d     = '0;
		rsp_d.status = ST_OK;
		rsp_d.last   = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = src_idx_q;
		wr_en     = 1'b0;
		wr_addr   = ff_idx;
		wr_data   = h_q;
		bm_we     = 1'b0;
		bm_idx    = ff_idx;
		bm_used   = 1'b0;
		bm_cx     = 1'b0;
		vis_set   = 1'b0;
		cand_load = 1'b0;
		pend_load = 1'b0;
		tmp_load  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = req.slot_index[IW-1:0];
					state_d = S_LOOK;
				end
			end

			S_LOOK: begin
				case (mode_q)
					MODE_CREATE: begin
						if (can_emit) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (bad_q || h_q == '0) begin
								rsp_d.status = ST_INVAL;
							end else if (!ff_found) begin
								rsp_d.status = ST_FULL;
							end else begin
								wr_en          = 1'b1;
								bm_we          = 1'b1;
								bm_used        = 1'b1;
								bm_cx          = cl_q;
								rsp_d.slot_out = SLOT_OUT_W'(ff_idx);
							end
						end
					end
					MODE_REMOVE: begin
						if (h_q != '0) begin
							state_d = S_RM_ISSUE;
						end else if (can_emit) begin
							emit         = 1'b1;
							rsp_d.status = ST_INVAL;
							state_d      = S_IDLE;
						end
					end
					MODE_LOOKUP: begin
						if (can_emit) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (!src_ok) begin
								rsp_d.status = ST_BADF;
							end else begin
								rsp_d.file_out = HANDLE_W'(rd_q);
							end
						end
					end
					MODE_EXEC: begin
						state_d = S_XC_ISSUE;
					end
					MODE_DUP: begin
						if (can_emit) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (!src_ok) begin
								rsp_d.status = ST_BADF;
							end else if (!ff_found) begin
								rsp_d.status = ST_FULL;
							end else begin
								wr_en          = 1'b1;
								wr_data        = rd_q;
								bm_we          = 1'b1;
								bm_used        = 1'b1;
								rsp_d.slot_out = SLOT_OUT_W'(ff_idx);
							end
						end
					end
					MODE_DUP2: begin
						if (!bad_q && src_ok && dst_rng_q && src_idx_q != dst_idx_q) begin
							// Keep the source handle and read the target's old one.
							tmp_load = 1'b1;
							rd_en    = 1'b1;
							rd_addr  = dst_idx_q;
							state_d  = S_D2_WR;
						end else if (can_emit) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (bad_q) begin
								rsp_d.status = ST_INVAL;
							end else if (!src_ok || !dst_rng_q) begin
								rsp_d.status = ST_BADF;
							end
						end
					end
					default: begin
						if (can_emit) begin
							emit         = 1'b1;
							rsp_d.status = ST_INVAL;
							state_d      = S_IDLE;
						end
					end
				endcase
			end

			// Remove: visit the slots in use from the lowest, one memory read each.
			S_RM_ISSUE: begin
				if (ff_found) begin
					rd_en     = 1'b1;
					rd_addr   = ff_idx;
					cand_load = 1'b1;
					vis_set   = 1'b1;
					state_d   = S_RM_CMP;
				end else if (can_emit) begin
					emit         = 1'b1;
					rsp_d.status = ST_INVAL;
					state_d      = S_IDLE;
				end
			end

			S_RM_CMP: begin
				if (rd_q != h_q) begin
					state_d = S_RM_ISSUE;
				end else if (can_emit) begin
					emit    = 1'b1;
					bm_we   = 1'b1;
					bm_idx  = cand_q;
					state_d = S_IDLE;
				end
			end

			// Exec close: free each flagged slot; a close request is held back one step
			// so the final one can carry the last mark.
			S_XC_ISSUE: begin
				if (ff_found) begin
					rd_en   = 1'b1;
					rd_addr = ff_idx;
					bm_we   = 1'b1;
					state_d = S_XC_DATA;
				end else if (can_emit) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (pend_q) begin
						rsp_d.close_valid  = 1'b1;
						rsp_d.close_handle = HANDLE_W'(pend_h_q);
					end
				end
			end

			S_XC_DATA: begin
				if (!pend_q) begin
					pend_load = 1'b1;
					state_d   = S_XC_ISSUE;
				end else if (can_emit) begin
					emit               = 1'b1;
					rsp_d.close_valid  = 1'b1;
					rsp_d.close_handle = HANDLE_W'(pend_h_q);
					rsp_d.last         = 1'b0;
					pend_load          = 1'b1;
					state_d            = S_XC_ISSUE;
				end
			end

			// Dup2: install the source handle at the target and close what it held.
			S_D2_WR: begin
				if (can_emit) begin
					emit    = 1'b1;
					wr_en   = 1'b1;
					wr_addr = dst_idx_q;
					wr_data = tmp_q;
					bm_we   = 1'b1;
					bm_idx  = dst_idx_q;
					bm_used = 1'b1;
					bm_cx   = cl_q;
					if (used_q[dst_idx_q]) begin
						rsp_d.close_valid  = 1'b1;
						rsp_d.close_handle = HANDLE_W'(rd_q);
					end
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, bitmaps and the response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			cloexec_q   <= '0;
			vis_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (bm_we) begin
				used_q[bm_idx]    <= bm_used;
				cloexec_q[bm_idx] <= bm_cx;
			end
			if (accept) begin
				vis_q <= '0;
			end else if (vis_set) begin
				vis_q[ff_idx] <= 1'b1;
			end
			if (accept) begin
				pend_q <= 1'b0;
			end else if (pend_load) begin
				pend_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, scan registers and the response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= req.mode;
			h_q       <= req.file_handle[HW-1:0];
			src_idx_q <= req.slot_index[IW-1:0];
			dst_idx_q <= req.new_slot[IW-1:0];
			src_rng_q <= ({1'b0, req.slot_index} < (SLOT_W + 1)'(SLOTS));
			dst_rng_q <= ({1'b0, req.new_slot} < (SLOT_W + 1)'(SLOTS));
			cl_q      <= req.close_on_exec;
			bad_q     <= req.bad_flags;
		end
		if (cand_load) begin
			cand_q <= ff_idx;
		end
		if (pend_load) begin
			pend_h_q <= rd_q;
		end
		if (tmp_load) begin
			tmp_q <= rd_q;
		end
		if (emit) begin
			out_q <= rsp_d;
		end
	end

	// Handle memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.slot_out     = out_q.slot_out;
	assign rsp.file_out     = out_q.file_out;
	assign rsp.close_valid  = out_q.close_valid;
	assign rsp.close_handle = out_q.close_handle;
	assign rsp.last         = out_q.last;

`ifndef SYNTHESIS
	// A close-on-exec mark never survives on a free slot.
	a_cloexec_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cloexec_q & ~used_q) == '0)
		else $error("close-on-exec bit set on a free slot");

	// No slot past the configured count is ever allocated.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q & ~valid_mask) == '0)
		else $error("slot beyond the table marked in use");

	// Every handle written to memory makes its slot in use.
	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (bm_we && bm_used && bm_idx == wr_addr))
		else $error("memory write without marking the slot in use");

	// The final response of an operation returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && rsp_d.last) |=> (state_q == S_IDLE))
		else $error("final response issued without ending the operation");
`endif
endmodule
